### design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and types for the quaternion to Euler converter
// Word widths, the arctangent table and the records handed between cells.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_WIDTH    = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int FRAC_BITS     = QUAT_WIDTH - 2;
    localparam int PROD_W        = 2 * QUAT_WIDTH - FRAC_BITS + 1;
    localparam int SUM_W         = PROD_W + 1;
    localparam int CW            = SUM_W + 4;
    localparam int SQ_W          = 2 * FRAC_BITS + 1;
    localparam int RES_W         = SQ_W + 1;
    localparam int ROOT_STEPS    = FRAC_BITS + 1;
    localparam int CORDIC_CELLS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int ANG_W         = 32;
    localparam int SHIFT_W       = 5;
    localparam int FRONT_STAGES  = 3;
    localparam int PIPE_STAGES   = FRONT_STAGES + ROOT_STEPS + CORDIC_CELLS;
    localparam int SCALE_SHIFT   = ANG_W - ANGLE_WIDTH;

    // Rounded arctangent of 2^-i, binary angle with 2^31 = 180 degrees.
    localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     ang;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0]  rem;
        logic [RES_W-1:0] root;
    } root_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] hn;
        logic signed [SUM_W-1:0] hd;
        logic signed [SUM_W-1:0] rn;
        logic signed [SUM_W-1:0] rd;
        logic signed [SUM_W-1:0] sp;
        logic                    sat_pos;
        logic                    sat_neg;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [SQ_W-1:0] rem;
    } front_t;

endpackage

### design/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front: quaternion products and sums
// Three register stages: doubled products, the five atan operands, and the
// remainder 1 - s^2 with the pitch saturation flags.
// ----------------------------------------------------------------------------
module qte_front
    import qte_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    output front_t                       res
);

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

    logic signed [2*QUAT_WIDTH-1:0] p_wz, p_xy, p_yy, p_zz, p_wx, p_yz, p_xx, p_wy, p_zx;
    logic signed [PROD_W-1:0] wz_reg, xy_reg, yy_reg, zz_reg, wx_reg, yz_reg, xx_reg;
    logic signed [PROD_W-1:0] wy_reg, zx_reg;
    logic signed [SUM_W-1:0]  hn_reg, hd_reg, rn_reg, rd_reg, sp_reg;
    logic signed [2*SUM_W-1:0] sq;
    front_t res_reg;

    assign p_wz = quat_w * quat_z;
    assign p_xy = quat_x * quat_y;
    assign p_yy = quat_y * quat_y;
    assign p_zz = quat_z * quat_z;
    assign p_wx = quat_w * quat_x;
    assign p_yz = quat_y * quat_z;
    assign p_xx = quat_x * quat_x;
    assign p_wy = quat_w * quat_y;
    assign p_zx = quat_z * quat_x;
    assign sq   = sp_reg * sp_reg;

    // Taking the top bits is a floor shift that doubles the product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg <= p_wz[2*QUAT_WIDTH-1:FRAC_BITS-1];
            xy_reg <= p_xy[2*QUAT_WIDTH-1:FRAC_BITS-1];
            yy_reg <= p_yy[2*QUAT_WIDTH-1:FRAC_BITS-1];
            zz_reg <= p_zz[2*QUAT_WIDTH-1:FRAC_BITS-1];
            wx_reg <= p_wx[2*QUAT_WIDTH-1:FRAC_BITS-1];
            yz_reg <= p_yz[2*QUAT_WIDTH-1:FRAC_BITS-1];
            xx_reg <= p_xx[2*QUAT_WIDTH-1:FRAC_BITS-1];
            wy_reg <= p_wy[2*QUAT_WIDTH-1:FRAC_BITS-1];
            zx_reg <= p_zx[2*QUAT_WIDTH-1:FRAC_BITS-1];

            hn_reg <= SUM_W'(wz_reg) + SUM_W'(xy_reg);
            hd_reg <= ONE - SUM_W'(yy_reg) - SUM_W'(zz_reg);
            rn_reg <= SUM_W'(wx_reg) + SUM_W'(yz_reg);
            rd_reg <= ONE - SUM_W'(xx_reg) - SUM_W'(yy_reg);
            sp_reg <= SUM_W'(wy_reg) - SUM_W'(zx_reg);

            res_reg.side.hn      <= hn_reg;
            res_reg.side.hd      <= hd_reg;
            res_reg.side.rn      <= rn_reg;
            res_reg.side.rd      <= rd_reg;
            res_reg.side.sp      <= sp_reg;
            res_reg.side.sat_pos <= (sp_reg >= ONE);
            res_reg.side.sat_neg <= (sp_reg <= -ONE);
            res_reg.rem          <= ONE_SQ - sq[SQ_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

### design/qte_root_cell.sv
// ----------------------------------------------------------------------------
// qte_root_cell: one step of the integer square root
// Tries one result bit against the running remainder and registers the pair.
// ----------------------------------------------------------------------------
module qte_root_cell
    import qte_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [RES_W-1:0] bit_val,
    input  root_t            din,
    output root_t            dout
);

    logic [RES_W-1:0] trial;
    logic [RES_W-1:0] rem_ext;
    root_t            dout_next;
    root_t            dout_reg;

    always_comb
    begin
        trial   = din.root + bit_val;
        rem_ext = RES_W'(din.rem);
        if (rem_ext >= trial)
        begin
            dout_next.rem  = SQ_W'(rem_ext - trial);
            dout_next.root = (din.root >> 1) + bit_val;
        end
        else
        begin
            dout_next.rem  = din.rem;
            dout_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

### design/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by the arctangent of 2^-shift and registers.
// ----------------------------------------------------------------------------
module qte_cordic_cell
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [SHIFT_W-1:0] shift,
    input  logic [ANG_W-1:0]   atan_val,
    input  cordic_t            din,
    output cordic_t            dout
);

    logic signed [CW-1:0] dx, dy;
    logic                 y_pos;
    cordic_t              dout_next;
    cordic_t              dout_reg;

    always_comb
    begin
        dx    = $signed(din.y) >>> shift;
        dy    = $signed(din.x) >>> shift;
        y_pos = !din.y[CW-1] && (din.y != '0);
        dout_next.zero = din.zero;
        if (y_pos)
        begin
            dout_next.x   = din.x + dx;
            dout_next.y   = din.y - dy;
            dout_next.ang = din.ang + atan_val;
        end
        else
        begin
            dout_next.x   = din.x - dx;
            dout_next.y   = din.y + dy;
            dout_next.ang = din.ang - atan_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

### design/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: fixed-point quaternion to heading, roll, pitch
// Pipelined conversion: products, a square-root cell chain, CORDIC cell chains.
// ----------------------------------------------------------------------------
// The input channel (quat_valid, quat_stall) carries one quaternion per
// transaction as four signed Q1.14 components. The output channel
// (angle_valid, angle_stall) carries heading, roll and pitch as signed binary
// angles, where 32768 stands for 180 degrees. A transaction completes at a
// rising edge where valid is high and stall is low.
// The block accepts one quaternion every cycle while quat_stall is low. A
// result passes through three product and sum registers, the first loading on
// the accepting edge, then fifteen square-root cells, sixteen CORDIC cells and
// the output register. The square-root chain for the pitch cosine sets this
// depth; the heading and roll operands ride along beside it.
// When the receiver stalls a waiting result, the pipeline keeps moving as long
// as its last stage is empty, so new quaternions are still taken. It freezes,
// and quat_stall rises, only when a finished result sits behind a stalled one.
// Reset clears the valid bits of every stage and of the output register; the
// datapath registers carry no control state, so nothing else needs clearing.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quat_valid,
    output logic                          quat_stall,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic                          angle_valid,
    input  logic                          angle_stall,
    output logic signed [ANGLE_WIDTH-1:0] heading_angle,
    output logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic signed [ANGLE_WIDTH-1:0] pitch_angle
);

    localparam int AX = ANG_W + 1;
    localparam logic signed [AX-1:0] ROUND =
        (SCALE_SHIFT > 0) ? (AX'(1) << (SCALE_SHIFT - 1)) : '0;
    localparam logic signed [AX-1:0] LIMX = AX'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH-1:0] LIM = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (ANG_W - 1);

    // A whole pipeline step happens on adv. It is held back only when the
    // last stage has a result and the output register cannot take it.
    logic adv;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic angle_valid_reg;

    front_t  front_res;
    side_t   side_reg [ROOT_STEPS];
    root_t   rst_w    [ROOT_STEPS+1];
    logic [1:0] sat_reg [CORDIC_CELLS];
    cordic_t cst [3][CORDIC_CELLS+1];

    logic signed [ANGLE_WIDTH-1:0] heading_reg, roll_reg, pitch_reg;
    logic signed [ANGLE_WIDTH-1:0] heading_next, roll_next, pitch_next;

    assign adv        = !vld_reg[PIPE_STAGES-1] || !angle_valid_reg || !angle_stall;
    assign quat_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            angle_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[PIPE_STAGES-2:0], quat_valid};
            if (adv && vld_reg[PIPE_STAGES-1])
                angle_valid_reg <= 1'b1;
            else if (!angle_stall)
                angle_valid_reg <= 1'b0;
        end
    end

    qte_front u_front (
        .clk    (clk),
        .en     (adv),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .res    (front_res)
    );

    // Square root of 1 - s^2, one result bit per cell. The heading and roll
    // operands travel alongside so all three arctangents start together.
    assign rst_w[0].rem  = front_res.rem;
    assign rst_w[0].root = '0;

    genvar j, k, ch;
    generate
        for (j = 0; j < ROOT_STEPS; j++)
        begin : g_root
            localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * FRAC_BITS - 2 * j);

            qte_root_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .bit_val (BIT),
                .din     (rst_w[j]),
                .dout    (rst_w[j+1])
            );

            if (j == 0)
            begin : g_side_first
                always_ff @(posedge clk)
                begin
                    if (adv)
                        side_reg[j] <= front_res.side;
                end
            end
            else
            begin : g_side_rest
                always_ff @(posedge clk)
                begin
                    if (adv)
                        side_reg[j] <= side_reg[j-1];
                end
            end
        end
    endgenerate

    // Entry into the CORDIC: an operand with negative x is turned by half a
    // turn first; both operands zero is flagged so the angle reads as zero.
    function automatic cordic_t cordic_entry(logic signed [CW-1:0] yv,
                                             logic signed [CW-1:0] xv);
        cordic_t c;
        c.zero = (xv == '0) && (yv == '0);
        if (xv[CW-1])
        begin
            c.x   = -xv;
            c.y   = -yv;
            c.ang = HALF_TURN;
        end
        else
        begin
            c.x   = xv;
            c.y   = yv;
            c.ang = '0;
        end
        return c;
    endfunction

    assign cst[0][0] = cordic_entry(CW'(side_reg[ROOT_STEPS-1].hn),
                                    CW'(side_reg[ROOT_STEPS-1].hd));
    assign cst[1][0] = cordic_entry(CW'(side_reg[ROOT_STEPS-1].rn),
                                    CW'(side_reg[ROOT_STEPS-1].rd));
    assign cst[2][0] = cordic_entry(CW'(side_reg[ROOT_STEPS-1].sp),
                                    CW'(rst_w[ROOT_STEPS].root[FRAC_BITS:0]));

    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_chain
            for (k = 0; k < CORDIC_CELLS; k++)
            begin : g_cell
                qte_cordic_cell u_cell (
                    .clk      (clk),
                    .en       (adv),
                    .shift    (SHIFT_W'(k)),
                    .atan_val (ATAN_TAB[k]),
                    .din      (cst[ch][k]),
                    .dout     (cst[ch][k+1])
                );
            end
        end

        for (k = 0; k < CORDIC_CELLS; k++)
        begin : g_sat
            if (k == 0)
            begin : g_sat_first
                always_ff @(posedge clk)
                begin
                    if (adv)
                        sat_reg[k] <= {side_reg[ROOT_STEPS-1].sat_pos,
                                       side_reg[ROOT_STEPS-1].sat_neg};
                end
            end
            else
            begin : g_sat_rest
                always_ff @(posedge clk)
                begin
                    if (adv)
                        sat_reg[k] <= sat_reg[k-1];
                end
            end
        end
    endgenerate

    // Round the 32-bit angle to the output width.
    function automatic logic signed [AX-1:0] scale_angle(cordic_t c);
        logic [ANG_W-1:0]     a;
        logic signed [AX-1:0] v;
        a = c.zero ? '0 : c.ang;
        v = $signed({a[ANG_W-1], a}) + ROUND;
        return v >>> SCALE_SHIFT;
    endfunction

    logic signed [AX-1:0] sc_head, sc_roll, sc_pitch;

    always_comb
    begin
        sc_head  = scale_angle(cst[0][CORDIC_CELLS]);
        sc_roll  = scale_angle(cst[1][CORDIC_CELLS]);
        sc_pitch = scale_angle(cst[2][CORDIC_CELLS]);
        // Heading and roll wrap at plus 180 degrees by truncation.
        heading_next = sc_head[ANGLE_WIDTH-1:0];
        roll_next    = sc_roll[ANGLE_WIDTH-1:0];
        if (sat_reg[CORDIC_CELLS-1][1])
            pitch_next = LIM;
        else if (sat_reg[CORDIC_CELLS-1][0])
            pitch_next = -LIM;
        else if (sc_pitch > LIMX)
            pitch_next = LIM;
        else if (sc_pitch < -LIMX)
            pitch_next = -LIM;
        else
            pitch_next = sc_pitch[ANGLE_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[PIPE_STAGES-1])
        begin
            heading_reg <= heading_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
        end
    end

    assign angle_valid   = angle_valid_reg;
    assign heading_angle = heading_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;

    // Pitch never leaves the quarter-turn range.
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (pitch_angle <= LIM) && (pitch_angle >= -LIM))
        else $error("pitch outside +-90 degrees");

    // A blocked result freezes every stage of the pipeline.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall && vld_reg[PIPE_STAGES-1] |=> $stable(vld_reg))
        else $error("pipeline moved while its result was blocked");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && !angle_stall && !vld_reg[PIPE_STAGES-1] |=> !angle_valid)
        else $error("result repeated after transaction");

endmodule

### bench/tb_quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles: self-checking bench for the Euler converter
// Drives quaternions through the input channel with random gaps and output
// stalls, predicts heading, roll and pitch with an independent fixed-point
// CORDIC model, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    localparam int  LATENCY    = PIPE_STAGES + 8;
    localparam int  RANDOM_CNT = 530;
    localparam int  QUIET_CNT  = 60;

    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    typedef struct packed {
        angle_t heading;
        angle_t roll;
        angle_t pitch;
    } euler_t;

    logic  clk;
    logic  rst_n;
    logic  quat_valid;
    logic  quat_stall;
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    logic  angle_valid;
    logic  angle_stall;
    angle_t heading_angle;
    angle_t roll_angle;
    angle_t pitch_angle;

    // Expected Euler triples, oldest first.
    euler_t pending_angles[$];
    int     error_count;
    // Once set, neither side idles any more.
    bit     quiet;

    quaternion_to_euler_angles u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .quat_valid    (quat_valid),
        .quat_stall    (quat_stall),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .angle_valid   (angle_valid),
        .angle_stall   (angle_stall),
        .heading_angle (heading_angle),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Doubled product 2ab, keeping FRAC_BITS fraction bits (floor shift).
    function automatic longint twice_product(longint a, longint b);
        return (a * b) >>> (FRAC_BITS - 1);
    endfunction

    // Floor integer square root, one result bit per step.
    function automatic longint floor_sqrt(longint v);
        longint rest;
        longint root;
        longint bitv;
        rest = v;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > rest)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (rest >= root + bitv)
            begin
                rest = rest - (root + bitv);
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC arctangent, 32-bit binary angle, no gain correction.
    function automatic logic [31:0] cordic_angle(longint yin, longint xin);
        longint      xv;
        longint      yv;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        xv = xin;
        yv = yin;
        acc = '0;
        if (xv == 0 && yv == 0)
            return '0;
        // The left half plane is folded over by a half turn first.
        if (xv < 0)
        begin
            xv = -xv;
            yv = -yv;
            acc = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_CELLS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                acc = acc + ATAN_TAB[i];
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                acc = acc - ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    // Round the 32-bit angle to the output width (half step added, floor).
    function automatic longint round_angle(logic [31:0] a);
        longint v;
        v = longint'($signed(a));
        return (v + (64'sd1 <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    endfunction

    function automatic euler_t euler_of(quat_t qw, quat_t qx, quat_t qy, quat_t qz);
        longint w;
        longint x;
        longint y;
        longint z;
        longint one;
        longint lim;
        longint sin_term;
        longint cos_term;
        longint pitch;
        euler_t e;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        one = 64'sd1 <<< FRAC_BITS;
        lim = 64'sd1 <<< (ANGLE_WIDTH - 2);
        sin_term = twice_product(w, y) - twice_product(z, x);
        if (sin_term >= one)
            pitch = lim;
        else if (sin_term <= -one)
            pitch = -lim;
        else
        begin
            cos_term = floor_sqrt((64'sd1 <<< (2 * FRAC_BITS)) - sin_term * sin_term);
            pitch = round_angle(cordic_angle(sin_term, cos_term));
            if (pitch > lim)
                pitch = lim;
            if (pitch < -lim)
                pitch = -lim;
        end
        // Truncation to the port width wraps +180 degrees to -180.
        e.heading = angle_t'(round_angle(cordic_angle(
            twice_product(w, z) + twice_product(x, y),
            one - twice_product(y, y) - twice_product(z, z))));
        e.roll = angle_t'(round_angle(cordic_angle(
            twice_product(w, x) + twice_product(y, z),
            one - twice_product(x, x) - twice_product(y, y))));
        e.pitch = angle_t'(pitch);
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (pending_angles.size() == 0)
                report_mismatch("unexpected result, heading", heading_angle, 0);
            else
            begin
                want = pending_angles.pop_front();
                if (heading_angle !== want.heading)
                    report_mismatch("heading", heading_angle, want.heading);
                if (roll_angle !== want.roll)
                    report_mismatch("roll", roll_angle, want.roll);
                if (pitch_angle !== want.pitch)
                    report_mismatch("pitch", pitch_angle, want.pitch);
            end
        end
    end

    // Receiver stalls in bursts; it goes quiet in the closing part of the run.
    initial
    begin
        int n;
        angle_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                angle_stall = 1'b1;
                repeat (n) @(negedge clk);
                angle_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Presents one quaternion from a falling edge and returns on the falling
    // edge after the transaction, leaving valid high for a following item.
    task automatic send_quat(quat_t w, quat_t x, quat_t y, quat_t z);
        quat_valid = 1'b1;
        quat_w = w;
        quat_x = x;
        quat_y = y;
        quat_z = z;
        do
            @(posedge clk);
        while (quat_stall);
        pending_angles.push_back(euler_of(w, x, y, z));
        @(negedge clk);
    endtask

    // Sender gap of a random burst length, at random.
    task automatic maybe_pause();
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 10);
            quat_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic test_extremes();
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 1, 1, 1);
    endtask

    task automatic test_special_cases();
        // Both arctangent operands of heading zero.
        send_quat(0, 0, 8192, 8192);
        // Pitch term at or beyond plus and minus one.
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(11585, 0, 11586, 0);
        send_quat(11585, 0, -11586, 0);
        send_quat(0, -16384, 0, 16384);
        // Pitch just inside the limits, where rounding may pass 90 degrees.
        send_quat(11585, 0, 11584, 0);
        send_quat(11585, 0, -11584, 0);
        // Negative x operands: half-turn fold, and wrap at 180 degrees.
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(1, 0, 0, -16384);
        send_quat(-1, 0, 0, 16384);
        send_quat(0, 16384, 0, 1);
        // A quaternion far from unit length.
        send_quat(3000, -200, 100, 50);
    endtask

    function automatic quat_t unit_part();
        return quat_t'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            // Mostly components within plus and minus one, the rest anywhere in range.
            if ($urandom_range(0, 3) != 0)
                send_quat(unit_part(), unit_part() >>> $urandom_range(0, 1),
                          unit_part() >>> $urandom_range(0, 1), unit_part());
            else
                send_quat(quat_t'($urandom), quat_t'($urandom),
                          quat_t'($urandom), quat_t'($urandom));
            maybe_pause();
        end
    endtask

    initial
    begin
        error_count = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        quat_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_special_cases();
        test_random(RANDOM_CNT - QUIET_CNT);
        quiet = 1'b1;
        test_random(QUIET_CNT);
        quat_valid = 1'b0;

        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
